// ===== rtl/core/dru_pkg.sv =====
// ----------------------------------------------------------------------------
// dru_pkg
// Shared widths, register indexes, reset values and record types of the
// detection row decoder.
// ----------------------------------------------------------------------------
package dru_pkg;

    localparam int ELEM_W      = 20;   // row element, signed
    localparam int SCORE_W     = 16;   // class score, Q0.16
    localparam int CLASS_W     = 8;
    localparam int INV_W       = 24;   // inverse scale, Q8.16
    localparam int PAD_W       = 12;
    localparam int DIM_W       = 14;   // frame size, box size
    localparam int COORD_W     = 13;   // box corner
    localparam int POS_W       = 9;    // up to 4 + 80 elements in a row
    localparam int BOX_VALUES  = 4;
    localparam int BOX_IDX_W   = $clog2(BOX_VALUES);
    localparam int MAX_CLASSES = 80;
    localparam int LANES       = 4;

    // Mapping datapath
    localparam int OPER_W      = 22;                 // 2*c - size - 32*pad
    localparam int PROD_W      = OPER_W + INV_W + 1; // signed product
    localparam int RND_W       = 27;                 // rounded pixel value
    localparam int SHIFT_POS   = 21;                 // Q.5 * Q.16
    localparam int SHIFT_SIZE  = 20;                 // Q.4 * Q.16

    // Queue between front and back, any depth of two or more
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_FIELD_W = 2 * COORD_W + 2 * DIM_W + CLASS_W + SCORE_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SCORE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_SCALE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_X           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_Y           = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 3'd6;

    // Reset values
    localparam logic [SCORE_W-1:0] RST_MIN_SCORE       = 16'd16384;
    localparam logic [CLASS_W-1:0] RST_CLASS_COUNT     = 8'd80;
    localparam logic [INV_W-1:0]   RST_INVERSE_SCALE   = 24'd65536;
    localparam logic [PAD_W-1:0]   RST_PAD             = 12'd0;
    localparam logic [DIM_W-1:0]   RST_FRAME_DIM       = 14'd640;

    localparam logic [INV_W-1:0]   UNIT_SCALE          = 24'd65536;
    localparam logic [DIM_W-1:0]   MAX_FRAME_DIM       = 14'd8192;

    // Effective configuration, already saturated
    typedef struct packed {
        logic [SCORE_W-1:0] min_score;
        logic [CLASS_W-1:0] class_count;
        logic [INV_W-1:0]   inverse_scale;
        logic [PAD_W-1:0]   pad_x;
        logic [PAD_W-1:0]   pad_y;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
    } cfg_t;

    // One finished row that passed the score threshold
    typedef struct packed {
        logic signed [ELEM_W-1:0] cx;
        logic signed [ELEM_W-1:0] cy;
        logic signed [ELEM_W-1:0] w;
        logic signed [ELEM_W-1:0] h;
        logic [SCORE_W-1:0]       score;
        logic [CLASS_W-1:0]       class_id;
    } rec_t;

    // One emitted box
    typedef struct packed {
        logic [SCORE_W-1:0] confidence;
        logic [CLASS_W-1:0] class_index;
        logic [DIM_W-1:0]   box_height;
        logic [DIM_W-1:0]   box_width;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_left;
    } res_t;

endpackage

// ===== rtl/core/detection_row_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// detection_row_decoder_unit
// Decodes detection prediction rows streamed element by element into
// clamped pixel boxes with their best class and confidence.
// ----------------------------------------------------------------------------
// Throughput: one row element per cycle, rows back to back, while the queue has
//   room; set by the row parser, which handles one element per cycle with a
//   one-step max compare. A box leaves through the queue, operand, multiply,
//   round, clamp, far edge and output registers after its row's last score.
// Reset (rst_n low, asynchronous): configuration registers take their default
//   values, the row counter returns to the start of a row and the queue empties.
module detection_row_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [dru_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dru_pkg::CFG_DATA_W-1:0]      cfg_data,
    // row elements
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dru_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [19:0] element
    // decoded boxes
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dru_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [12:0] box_left,
    // [25:13] box_top, [39:26] box_width, [53:40] box_height,
    // [61:54] class_index, [77:62] confidence, [79:78] zero
);
    import dru_pkg::*;

    // Configuration registers, raw as written
    logic [SCORE_W-1:0] min_score_reg;
    logic [CLASS_W-1:0] class_count_reg;
    logic [INV_W-1:0]   inverse_scale_reg;
    logic [PAD_W-1:0]   pad_x_reg;
    logic [PAD_W-1:0]   pad_y_reg;
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;

    cfg_t  cfg;
    logic  q_push, q_full, q_pop, q_valid, back_ready;
    rec_t  q_push_rec, q_pop_rec;
    res_t  back_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_score_reg       <= RST_MIN_SCORE;
            class_count_reg     <= RST_CLASS_COUNT;
            inverse_scale_reg   <= RST_INVERSE_SCALE;
            pad_x_reg           <= RST_PAD;
            pad_y_reg           <= RST_PAD;
            frame_width_reg     <= RST_FRAME_DIM;
            frame_height_reg    <= RST_FRAME_DIM;
        end
        else if (cfg_write)
        begin
            // indexes beyond the register list are ignored
            case (cfg_index)
                REG_MIN_SCORE:       min_score_reg       <= cfg_data[SCORE_W-1:0];
                REG_CLASS_COUNT:     class_count_reg     <= cfg_data[CLASS_W-1:0];
                REG_INVERSE_SCALE:   inverse_scale_reg   <= cfg_data[INV_W-1:0];
                REG_PAD_X:           pad_x_reg           <= cfg_data[PAD_W-1:0];
                REG_PAD_Y:           pad_y_reg           <= cfg_data[PAD_W-1:0];
                REG_FRAME_WIDTH:     frame_width_reg     <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective settings: saturate the class count to 1..MAX_CLASSES, treat a
    // zero scale as 1.0 and saturate frame dimensions to 1..8192.
    always_comb
    begin
        cfg.min_score = min_score_reg;
        cfg.pad_x     = pad_x_reg;
        cfg.pad_y     = pad_y_reg;

        if (class_count_reg == '0)
            cfg.class_count = CLASS_W'(1);
        else if (class_count_reg > CLASS_W'(MAX_CLASSES))
            cfg.class_count = CLASS_W'(MAX_CLASSES);
        else
            cfg.class_count = class_count_reg;

        cfg.inverse_scale = (inverse_scale_reg == '0) ? UNIT_SCALE : inverse_scale_reg;

        if (frame_width_reg == '0)
            cfg.frame_width = DIM_W'(1);
        else if (frame_width_reg > MAX_FRAME_DIM)
            cfg.frame_width = MAX_FRAME_DIM;
        else
            cfg.frame_width = frame_width_reg;

        if (frame_height_reg == '0)
            cfg.frame_height = DIM_W'(1);
        else if (frame_height_reg > MAX_FRAME_DIM)
            cfg.frame_height = MAX_FRAME_DIM;
        else
            cfg.frame_height = frame_height_reg;
    end

    // Front: parse each transaction of the row, push surviving rows
    dru_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .elem_valid (s_axis_tvalid),
        .elem_ready (s_axis_tready),
        .element    ($signed(s_axis_tdata[ELEM_W-1:0])),
        .push       (q_push),
        .push_rec   (q_push_rec),
        .full       (q_full)
    );

    // Queue: lets the parser keep taking elements while the back stalls
    dru_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .pop_rec  (q_pop_rec),
        .valid    (q_valid)
    );

    assign q_pop = q_valid && back_ready;

    // Back: map, clamp and emit one record per cycle unless the output stalls
    dru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (q_valid),
        .in_ready  (back_ready),
        .in_rec    (q_pop_rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (back_res)
    );

    // Pack the result fields, box_left in the lowest bits
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, back_res};

endmodule

// ===== rtl/core/dru_front.sv =====
// ----------------------------------------------------------------------------
// dru_front
// Row parser: store the box values, track the best class score and push a
// record for every row whose best score reaches the threshold.
// ----------------------------------------------------------------------------
module dru_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dru_pkg::cfg_t                     cfg,
    input  logic                              elem_valid,
    output logic                              elem_ready,
    input  logic signed [dru_pkg::ELEM_W-1:0] element,
    output logic                              push,
    output dru_pkg::rec_t                     push_rec,
    input  logic                              full
);
    import dru_pkg::*;

    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [SCORE_W-1:0]       best_reg, best_next;
    logic [CLASS_W-1:0]       class_reg, class_next;
    logic signed [ELEM_W-1:0] box_reg [BOX_VALUES];

    logic               accept;
    logic               in_box;
    logic               row_end;
    logic               take;
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   last_pos;

    assign elem_ready = !full;
    assign accept     = elem_valid && elem_ready;

    always_comb
    begin
        // negative scores count as zero, large ones saturate
        if (element[ELEM_W-1])
            score = '0;
        else if (|element[ELEM_W-2:SCORE_W])
            score = '1;
        else
            score = element[SCORE_W-1:0];

        in_box   = pos_reg < POS_W'(BOX_VALUES);
        last_pos = POS_W'(cfg.class_count) + POS_W'(BOX_VALUES - 1);
        row_end  = !in_box && (pos_reg >= last_pos);

        // first score of the row always loads, later ones only if strictly higher
        take       = (pos_reg == POS_W'(BOX_VALUES)) || (score > best_reg);
        best_next  = take ? score : best_reg;
        class_next = take ? CLASS_W'(pos_reg - POS_W'(BOX_VALUES)) : class_reg;

        pos_next = pos_reg;
        if (accept)
            pos_next = row_end ? '0 : pos_reg + POS_W'(1);

        push              = accept && row_end && (best_next >= cfg.min_score);
        push_rec.cx       = box_reg[0];
        push_rec.cy       = box_reg[1];
        push_rec.w        = box_reg[2];
        push_rec.h        = box_reg[3];
        push_rec.score    = best_next;
        push_rec.class_id = class_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            best_reg  <= '0;
            class_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (accept && !in_box)
            begin
                best_reg  <= best_next;
                class_reg <= class_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_box)
            box_reg[pos_reg[BOX_IDX_W-1:0]] <= element;
    end

    // The counter never runs past the longest row.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(BOX_VALUES - 1 + MAX_CLASSES))
        else $error("row position ran past the longest row");

endmodule

// ===== rtl/core/dru_queue.sv =====
// ----------------------------------------------------------------------------
// dru_queue
// Short record queue between the row parser and the mapping pipeline.
// ----------------------------------------------------------------------------
module dru_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dru_pkg::rec_t push_rec,
    output logic          full,
    input  logic          pop,
    output dru_pkg::rec_t pop_rec,
    output logic          valid
);
    import dru_pkg::*;

    rec_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full    = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign pop_rec = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("record pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("record popped from an empty queue");

    a_pointers_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with an empty count");

endmodule

// ===== rtl/core/dru_back.sv =====
// ----------------------------------------------------------------------------
// dru_back
// Mapping pipeline: offset, scale, round, clamp and area check of one record
// per cycle unless the output stalls, ending in the output register.
// ----------------------------------------------------------------------------
module dru_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dru_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  dru_pkg::rec_t in_rec,
    output logic          out_valid,
    input  logic          out_ready,
    output dru_pkg::res_t out_res
);
    import dru_pkg::*;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] class_id;
    } meta_t;

    // stage valids and ready chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_load;

    // stage payload
    meta_t                    meta1_reg, meta2_reg, meta3_reg, meta4_reg, meta5_reg;
    logic signed [OPER_W-1:0] oper_reg [LANES];
    logic signed [OPER_W-1:0] oper_next [LANES];
    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PROD_W-1:0] prod_next [LANES];
    logic signed [PROD_W-1:0] rsum [LANES];
    logic signed [RND_W-1:0]  rnd_reg [LANES];
    logic signed [RND_W-1:0]  rnd_next [LANES];
    logic [COORD_W-1:0]       x4_reg, y4_reg, x4_next, y4_next, x5_reg, y5_reg;
    logic signed [RND_W-1:0]  wd4_reg, ht4_reg;
    logic [DIM_W-1:0]         x2_reg, y2_reg, x2_next, y2_next;
    logic signed [RND_W-1:0]  sumx, sumy;
    logic [COORD_W-1:0]       fw_m1, fh_m1;
    logic signed [PROD_W-1:0] inv_ext;
    logic                     keep;
    res_t                     res_reg, res_next;

    assign out_load = !out_valid_reg || out_ready;
    assign s5_ready = !s5_valid_reg || out_load;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    assign fw_m1   = COORD_W'(cfg.frame_width - DIM_W'(1));
    assign fh_m1   = COORD_W'(cfg.frame_height - DIM_W'(1));
    assign inv_ext = $signed({{(PROD_W - INV_W){1'b0}}, cfg.inverse_scale});

    always_comb
    begin
        // operands: corners in Q.5 with the padding removed, sizes in Q.4
        oper_next[0] = $signed((OPER_W'(in_rec.cx) <<< 1) - OPER_W'(in_rec.w)
                               - OPER_W'({cfg.pad_x, 5'b0}));
        oper_next[1] = $signed((OPER_W'(in_rec.cy) <<< 1) - OPER_W'(in_rec.h)
                               - OPER_W'({cfg.pad_y, 5'b0}));
        oper_next[2] = OPER_W'(in_rec.w);
        oper_next[3] = OPER_W'(in_rec.h);

        for (int i = 0; i < LANES; i++)
        begin
            prod_next[i] = PROD_W'(oper_reg[i]) * inv_ext;
        end

        // round half away from zero: add half, one less for negative values
        for (int i = 0; i < LANES; i++)
        begin
            if (i < 2)
            begin
                rsum[i] = prod_reg[i]
                        + $signed((PROD_W'(1) << (SHIFT_POS - 1))
                                  - PROD_W'(prod_reg[i][PROD_W-1]));
                rnd_next[i] = RND_W'(rsum[i] >>> SHIFT_POS);
            end
            else
            begin
                rsum[i] = prod_reg[i]
                        + $signed((PROD_W'(1) << (SHIFT_SIZE - 1))
                                  - PROD_W'(prod_reg[i][PROD_W-1]));
                rnd_next[i] = RND_W'(rsum[i] >>> SHIFT_SIZE);
            end
        end

        // clamp the corner into the frame
        if (rnd_reg[0][RND_W-1])
            x4_next = '0;
        else if (rnd_reg[0] > $signed(RND_W'(fw_m1)))
            x4_next = fw_m1;
        else
            x4_next = rnd_reg[0][COORD_W-1:0];

        if (rnd_reg[1][RND_W-1])
            y4_next = '0;
        else if (rnd_reg[1] > $signed(RND_W'(fh_m1)))
            y4_next = fh_m1;
        else
            y4_next = rnd_reg[1][COORD_W-1:0];

        // far edges from the clamped corner
        sumx = $signed(RND_W'(x4_reg)) + wd4_reg;
        sumy = $signed(RND_W'(y4_reg)) + ht4_reg;

        if (sumx[RND_W-1])
            x2_next = '0;
        else if (sumx > $signed(RND_W'(cfg.frame_width)))
            x2_next = cfg.frame_width;
        else
            x2_next = sumx[DIM_W-1:0];

        if (sumy[RND_W-1])
            y2_next = '0;
        else if (sumy > $signed(RND_W'(cfg.frame_height)))
            y2_next = cfg.frame_height;
        else
            y2_next = sumy[DIM_W-1:0];

        // drop boxes with no area
        keep                 = (x2_reg > DIM_W'(x5_reg)) && (y2_reg > DIM_W'(y5_reg));
        res_next.box_left    = x5_reg;
        res_next.box_top     = y5_reg;
        res_next.box_width   = x2_reg - DIM_W'(x5_reg);
        res_next.box_height  = y2_reg - DIM_W'(y5_reg);
        res_next.class_index = meta5_reg.class_id;
        res_next.confidence  = meta5_reg.score;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg  <= in_valid;
            if (s2_ready) s2_valid_reg  <= s1_valid_reg;
            if (s3_ready) s3_valid_reg  <= s2_valid_reg;
            if (s4_ready) s4_valid_reg  <= s3_valid_reg;
            if (s5_ready) s5_valid_reg  <= s4_valid_reg;
            if (out_load) out_valid_reg <= s5_valid_reg && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            oper_reg  <= oper_next;
            meta1_reg <= '{score: in_rec.score, class_id: in_rec.class_id};
        end
        if (s2_ready)
        begin
            prod_reg  <= prod_next;
            meta2_reg <= meta1_reg;
        end
        if (s3_ready)
        begin
            rnd_reg   <= rnd_next;
            meta3_reg <= meta2_reg;
        end
        if (s4_ready)
        begin
            x4_reg    <= x4_next;
            y4_reg    <= y4_next;
            wd4_reg   <= rnd_reg[2];
            ht4_reg   <= rnd_reg[3];
            meta4_reg <= meta3_reg;
        end
        if (s5_ready)
        begin
            x5_reg    <= x4_reg;
            y5_reg    <= y4_reg;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            meta5_reg <= meta4_reg;
        end
        if (out_load)
            res_reg <= res_next;
    end

    a_nonzero_area: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.box_width != '0) && (res_reg.box_height != '0))
        else $error("box with zero area emitted");

    a_inside_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((DIM_W + 1)'(res_reg.box_left) + (DIM_W + 1)'(res_reg.box_width)
                 <= (DIM_W + 1)'(cfg.frame_width))
         && ((DIM_W + 1)'(res_reg.box_top) + (DIM_W + 1)'(res_reg.box_height)
                 <= (DIM_W + 1)'(cfg.frame_height)))
        else $error("emitted box reaches outside the frame");

endmodule

// ===== sim/tb_detection_row_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_detection_row_decoder_unit
// Streams prediction rows into the detection row decoder under random
// valid/ready gaps and compares every emitted box, field by field, with a
// built-in decoder of the same rows that tracks its own register copy.
// ----------------------------------------------------------------------------
module tb_detection_row_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import dru_pkg::*;

    localparam int TOTAL_ELEMENTS = 1650;  // stop random rows after this many
    localparam int DRAIN_CYCLES   = 12;    // wait after the last owed box, for stray ones
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all
    localparam int REPORT_LIMIT   = 10;
    localparam int CENTRE_SPAN    = 16 * 1200;  // Q15.4 centre range, pixels*16
    localparam int SIZE_SPAN      = 16 * 600;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // [19:0] element
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // [12:0] box_left, [25:13] box_top,
    // [39:26] box_width, [53:40] box_height, [61:54] class_index, [77:62] confidence

    detection_row_decoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder copy: register shadow and row state, as after reset
    // ------------------------------------------------------------------------
    logic [SCORE_W-1:0] cur_threshold     = RST_MIN_SCORE;
    logic [CLASS_W-1:0] cur_class_count   = RST_CLASS_COUNT;
    logic [INV_W-1:0]   cur_inverse_scale = RST_INVERSE_SCALE;
    logic [PAD_W-1:0]   cur_pad_x         = RST_PAD;
    logic [PAD_W-1:0]   cur_pad_y         = RST_PAD;
    logic [DIM_W-1:0]   cur_frame_width   = RST_FRAME_DIM;
    logic [DIM_W-1:0]   cur_frame_height  = RST_FRAME_DIM;

    int                 row_pos = 0;
    longint             box_val [BOX_VALUES];
    logic [SCORE_W-1:0] best_score = '0;
    logic [CLASS_W-1:0] best_class = '0;

    res_t boxes_due [$];        // boxes still owed by the block, oldest first

    int  mismatch_count = 0;
    int  elements_sent  = 0;
    int  idle_cycles    = 0;
    bit  tx_burst       = 1'b0; // sender runs without gaps while set
    bit  rx_burst       = 1'b0; // receiver runs without stalls while set

    initial
    begin
        foreach (box_val[i])
            box_val[i] = 0;
    end

    // number of scores per row, saturated to 1..MAX_CLASSES
    function automatic int row_classes();
        if (cur_class_count == 0)
            return 1;
        if (cur_class_count > MAX_CLASSES)
            return MAX_CLASSES;
        return int'(cur_class_count);
    endfunction

    function automatic longint frame_dim(input logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_FRAME_DIM)
            return longint'(MAX_FRAME_DIM);
        return longint'(d);
    endfunction

    // v / 2^s, rounded half away from zero
    function automatic longint round_away(input longint v, input int s);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (longint'(1) << (s - 1))) >> s;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the row state by one accepted element; queue a box when the
    // row closes at or above threshold with a non-empty clamped area.
    function automatic void decode_element(input logic [ELEM_W-1:0] raw);
        longint e, inv, fw, fh, left, top, wd, ht, x, y, x2, y2, bw, bh;
        int     score;
        res_t   box;
        e = $signed(raw);
        if (row_pos < BOX_VALUES)
        begin
            box_val[row_pos] = e;
            row_pos++;
            return;
        end
        // clip out-of-range scores into Q0.16
        score = (e < 0) ? 0 : ((e > 65535) ? 65535 : int'(e));
        if (row_pos == BOX_VALUES || score > int'(best_score))
        begin
            best_score = SCORE_W'(score);
            best_class = CLASS_W'(row_pos - BOX_VALUES);
        end
        // the end is taken from the count in force now, even mid-row
        if (row_pos < BOX_VALUES - 1 + row_classes())
        begin
            row_pos++;
            return;
        end
        row_pos = 0;
        if (best_score < cur_threshold)
            return;

        inv = (cur_inverse_scale == 0) ? longint'(UNIT_SCALE) : longint'(cur_inverse_scale);
        fw  = frame_dim(cur_frame_width);
        fh  = frame_dim(cur_frame_height);

        left = round_away((2 * box_val[0] - box_val[2] - 32 * longint'(cur_pad_x)) * inv,
                          SHIFT_POS);
        top  = round_away((2 * box_val[1] - box_val[3] - 32 * longint'(cur_pad_y)) * inv,
                          SHIFT_POS);
        wd   = round_away(box_val[2] * inv, SHIFT_SIZE);
        ht   = round_away(box_val[3] * inv, SHIFT_SIZE);

        // far edges come from the already clamped corner
        x  = clip(left, 0, fw - 1);
        y  = clip(top, 0, fh - 1);
        x2 = clip(x + wd, 0, fw);
        y2 = clip(y + ht, 0, fh);
        bw = (x2 - x > 0) ? x2 - x : 0;
        bh = (y2 - y > 0) ? y2 - y : 0;
        if (bw == 0 || bh == 0)
            return;

        box.box_left    = x[COORD_W-1:0];
        box.box_top     = y[COORD_W-1:0];
        box.box_width   = bw[DIM_W-1:0];
        box.box_height  = bh[DIM_W-1:0];
        box.class_index = best_class;
        box.confidence  = best_score;
        boxes_due = {boxes_due, box};
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers; each one starts and ends on a falling edge
    // ------------------------------------------------------------------------

    // Write one register and mirror it into the shadow copy.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_MIN_SCORE:       cur_threshold     = val[SCORE_W-1:0];
            REG_CLASS_COUNT:     cur_class_count   = val[CLASS_W-1:0];
            REG_INVERSE_SCALE:   cur_inverse_scale = val[INV_W-1:0];
            REG_PAD_X:           cur_pad_x         = val[PAD_W-1:0];
            REG_PAD_Y:           cur_pad_y         = val[PAD_W-1:0];
            REG_FRAME_WIDTH:     cur_frame_width   = val[DIM_W-1:0];
            REG_FRAME_HEIGHT:    cur_frame_height  = val[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int unsigned thr, input int unsigned cnt,
                             input int unsigned inv, input int unsigned px,
                             input int unsigned py, input int unsigned fw,
                             input int unsigned fh);
        write_reg(REG_MIN_SCORE,       CFG_DATA_W'(thr));
        write_reg(REG_CLASS_COUNT,     CFG_DATA_W'(cnt));
        write_reg(REG_INVERSE_SCALE,   CFG_DATA_W'(inv));
        write_reg(REG_PAD_X,           CFG_DATA_W'(px));
        write_reg(REG_PAD_Y,           CFG_DATA_W'(py));
        write_reg(REG_FRAME_WIDTH,     CFG_DATA_W'(fw));
        write_reg(REG_FRAME_HEIGHT,    CFG_DATA_W'(fh));
    endtask

    // Hold off for a random gap, then present one element until accepted.
    task automatic send_element(input logic [ELEM_W-1:0] e);
        int gap;
        if ($urandom_range(0, 63) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_TDATA_W'(e);
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_element(e);
        elements_sent++;
        @(negedge clk);   // tvalid stays high; the next call lowers it if it gaps
    endtask

    task automatic send_fixed_row(input int vals [6]);
        foreach (vals[i])
            send_element(ELEM_W'(vals[i]));
    endtask

    // One row of the current length. Well-formed rows carry plausible boxes
    // and scores, with the odd raw element, negative value and score tie;
    // noise rows are raw 20-bit words throughout.
    task automatic send_random_row(input bit well_formed);
        int               n;
        logic [ELEM_W-1:0] e;
        logic [ELEM_W-1:0] last_score;
        n = row_classes();
        last_score = '0;
        for (int k = 0; k < BOX_VALUES + n; k++)
        begin
            if (!well_formed || $urandom_range(0, 15) == 0)
                e = ELEM_W'($urandom());
            else if (k < 2)
                e = ELEM_W'($urandom_range(0, CENTRE_SPAN));
            else if (k < BOX_VALUES)
                e = ELEM_W'($urandom_range(1, SIZE_SPAN));
            else if (k > BOX_VALUES && $urandom_range(0, 5) == 0)
                e = last_score;
            else
                e = ELEM_W'($urandom_range(0, 65535));
            if (k >= BOX_VALUES)
                last_score = e;
            send_element(e);
        end
    endtask

    // Drop tvalid, wait for every owed box, then cover rows that end in no box.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (boxes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked rows of two scores: a plain box with a tied score, the
    // element extremes (clipped scores, zero-area box), a score just below
    // the threshold and one exactly at it with the box on the frame edge.
    task automatic test_directed_rows();
        write_all(16384, 2, 65536, 0, 0, 640, 480);
        send_fixed_row('{100 * 16, 80 * 16, 40 * 16, 20 * 16, 40000, 40000});
        send_fixed_row('{-524288, 524287, 524287, -524288, -524288, 524287});
        send_fixed_row('{50 * 16, 50 * 16, 10 * 16, 10 * 16, 16383, 0});
        send_fixed_row('{639 * 16 + 8, 479 * 16 + 8, 30 * 16 + 1, 30 * 16 + 1, 16384, 5});
        settle();
    endtask

    // Grow the count mid-row, then shrink it below the current position so
    // the very next score closes the row.
    task automatic test_count_change_mid_row();
        write_all(1000, 2, 98304, 16, 8, 1280, 720);
        send_element(ELEM_W'(300 * 16));
        send_element(ELEM_W'(200 * 16));
        send_element(ELEM_W'(120 * 16));
        send_element(ELEM_W'(90 * 16));
        send_element(ELEM_W'(20000));
        settle();
        write_reg(REG_CLASS_COUNT, CFG_DATA_W'(6));
        send_element(ELEM_W'(30000));
        send_element(ELEM_W'(12000));
        send_element(ELEM_W'(30000));
        settle();
        write_reg(REG_CLASS_COUNT, CFG_DATA_W'(1));
        send_element(ELEM_W'(45000));
        settle();
    endtask

    // Register extremes: zero count, scale and width, oversize height, max
    // padding; then the full-scale corner; then a scale too small for boxes.
    task automatic test_config_extremes();
        write_all(0, 0, 0, 4095, 4095, 0, 16383);
        repeat (14) send_random_row($urandom_range(0, 6) != 0);
        settle();
        write_all(65535, 255, 24'hFFFFFF, 0, 0, 8192, 1);
        repeat (2) send_random_row(1'b1);
        settle();
        write_all(1, 1, 1, 0, 0, 8192, 8192);
        repeat (8) send_random_row(1'b1);
        settle();
    endtask

    // Random register settings per phase; short rows dominate so that boxes
    // come often, with the odd full-length row.
    task automatic test_random_rows();
        int unsigned thr, cnt, inv, px, py, fw, fh;
        while (elements_sent < TOTAL_ELEMENTS)
        begin
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 65535;
                default: thr = $urandom_range(0, 50000);
            endcase
            case ($urandom_range(0, 15))
                0:       cnt = 0;
                1:       cnt = MAX_CLASSES;
                2:       cnt = $urandom_range(MAX_CLASSES + 1, 255);
                default: cnt = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 11))
                0:       inv = 0;
                1:       inv = 1;
                2:       inv = 24'hFFFFFF;
                default: inv = $urandom_range(32768, 196608);
            endcase
            px = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 160);
            py = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 160);
            case ($urandom_range(0, 11))
                0:       fw = 0;
                1:       fw = 1;
                2:       fw = 8192;
                3:       fw = $urandom_range(8193, 16383);
                default: fw = $urandom_range(320, 1920);
            endcase
            case ($urandom_range(0, 11))
                0:       fh = 0;
                1:       fh = 1;
                2:       fh = 8192;
                3:       fh = $urandom_range(8193, 16383);
                default: fh = $urandom_range(240, 1080);
            endcase
            write_all(thr, cnt, inv, px, py, fw, fh);
            repeat ((row_classes() <= 8) ? 16 : 2)
                send_random_row($urandom_range(0, 9) != 0);
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Box sink: stall at random, then check each accepted box against the
    // oldest one owed
    // ------------------------------------------------------------------------
    initial
    begin
        int   stall;
        res_t got;
        res_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got = m_axis_tdata[OUT_FIELD_W-1:0];
            if (boxes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected box left=%0d top=%0d w=%0d h=%0d cls=%0d conf=%0d",
                             $time, got.box_left, got.box_top, got.box_width,
                             got.box_height, got.class_index, got.confidence);
            end
            else
            begin
                want = boxes_due.pop_front();
                if (got.box_left !== want.box_left || got.box_top !== want.box_top ||
                    got.box_width !== want.box_width || got.box_height !== want.box_height ||
                    got.class_index !== want.class_index ||
                    got.confidence !== want.confidence)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: box mismatch, expected %0d/%0d/%0d/%0d cls %0d conf %0d, %s",
                                 $time, want.box_left, want.box_top, want.box_width,
                                 want.box_height, want.class_index, want.confidence,
                                 $sformatf("got %0d/%0d/%0d/%0d cls %0d conf %0d",
                                           got.box_left, got.box_top, got.box_width,
                                           got.box_height, got.class_index,
                                           got.confidence));
                end
            end
        end
    end

    // Watchdog: abort when neither side completes a transaction for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset once, then the tests in turn, then the verdict
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_rows();
        test_count_change_mid_row();
        test_config_extremes();
        test_random_rows();

        settle();
        if (mismatch_count == 0 && boxes_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dru_pkg.sv
rtl/core/dru_front.sv
rtl/core/dru_queue.sv
rtl/core/dru_back.sv
rtl/core/detection_row_decoder_unit.sv
sim/tb_detection_row_decoder_unit.sv
